// ----- hdl/tpz_pkg.sv -----
// shared types, constants and codes of the torus point depth-buffer plotter
`timescale 1ns / 1ps
package tpz_pkg;

	// default screen size
	localparam int SCREEN_WIDTH_DEF  = 200;
	localparam int SCREEN_HEIGHT_DEF = 160;

	// datapath widths
	localparam int DEN_W    = 50;
	localparam int ACC_W    = 64;
	localparam int MUL_A_W  = 34;
	localparam int MUL_B_W  = 18;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int Q_FRAC   = 14;
	localparam int SPLIT    = 24;
	localparam int DQ_SHIFT = 57;
	localparam int LUM_SHIFT = 53;
	localparam int SHADE_MAX = 11;
	localparam int DEPTH_W  = 16;
	localparam int SHADE_W  = 4;
	localparam int IDX_W    = 15;
	localparam int MEM_W    = DEPTH_W + SHADE_W;

	localparam logic [SHADE_W-1:0] BLANK = 4'd12;
	localparam logic signed [DEN_W-1:0] FIVE_Q42 = DEN_W'(5) <<< 42;
	localparam logic signed [17:0] TWO_Q14 = 18'sd32768;

	// action codes
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_PLOT  = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// register indexes
	localparam logic [1:0] CFG_COS_A = 2'd0;
	localparam logic [1:0] CFG_SIN_A = 2'd1;
	localparam logic [1:0] CFG_COS_B = 2'd2;
	localparam logic [1:0] CFG_SIN_B = 2'd3;

	// register reset values
	localparam logic signed [15:0] COS_RST = 16'sd8852;
	localparam logic signed [15:0] SIN_RST = 16'sd13787;

	// command queue
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_PLOT  = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic signed [15:0]       ct;
		logic signed [15:0]       st;
		logic signed [15:0]       cp;
		logic signed [15:0]       sp;
		logic signed [17:0]       h;
		logic [IDX_W-1:0]         idx;
		logic                     idx_ok;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] cos_a;
		logic signed [15:0] sin_a;
		logic signed [15:0] cos_b;
		logic signed [15:0] sin_b;
	} cfg_t;

	typedef struct packed {
		logic [SHADE_W-1:0] shade;
		logic               updated;
		logic [IDX_W-1:0]   index;
	} res_t;

	typedef struct packed {
		logic init_busy;
	} stat_t;

endpackage

// ----- hdl/tpz_div.sv -----
// unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module tpz_div
	import tpz_pkg::*;
#(
	parameter int DVD_W = 59,
	parameter int DVS_W = DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   sh_c;
	logic             ge_c;
	logic [DVS_W-1:0] rem_c;

	// trial subtract
	always_comb begin
		sh_c  = {rem_q, quo_q[DVD_W-1]};
		ge_c  = sh_c >= {1'b0, dvs_q};
		rem_c = ge_c ? DVS_W'(sh_c - {1'b0, dvs_q}) : sh_c[DVS_W-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_c;
			quo_q <= {quo_q[DVD_W-2:0], ge_c};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- hdl/tpz_front.sv -----
// front end: takes input items, classifies the action and forms a command
`timescale 1ns / 1ps
module tpz_front
	import tpz_pkg::*;
#(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        full,
	input  stat_t       stat,
	output logic        push,
	output cmd_t        cmd
);

	localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;

	assign s_axis_tready = !full && !stat.init_busy;
	assign push          = s_axis_tvalid && s_axis_tready;

	// classify and unpack
	always_comb begin
		case (s_axis_tuser)
			ACT_CLEAR: cmd.kind = KIND_CLEAR;
			ACT_PLOT:  cmd.kind = KIND_PLOT;
			ACT_READ:  cmd.kind = KIND_READ;
			default:   cmd.kind = KIND_NONE;
		endcase
		cmd.ct     = $signed(s_axis_tdata[15:0]);
		cmd.st     = $signed(s_axis_tdata[31:16]);
		cmd.cp     = $signed(s_axis_tdata[47:32]);
		cmd.sp     = $signed(s_axis_tdata[63:48]);
		cmd.idx    = s_axis_tdata[78:64];
		cmd.h      = 18'(cmd.ct) + TWO_Q14;
		cmd.idx_ok = 32'(cmd.idx) < 32'(PIXELS);
	end

endmodule

// ----- hdl/tpz_queue.sv -----
// short command queue between the front and back ends
`timescale 1ns / 1ps
module tpz_queue
	import tpz_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output cmd_t dout,
	output logic valid
);

	cmd_t               entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;

	assign full  = count_q == (Q_PTR_W + 1)'(Q_DEPTH);
	assign valid = count_q != '0;
	assign dout  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= din;
	end

endmodule

// ----- hdl/tpz_back.sv -----
// back end: rotation and projection sequencer, divider, depth-buffered store
`timescale 1ns / 1ps
module tpz_back
	import tpz_pkg::*;
#(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        cmd_valid,
	output logic        cmd_pop,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output stat_t       stat,
	output logic        out_valid,
	input  logic        out_ready,
	output res_t        out_res
);

	localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W = $clog2(PIXELS);
	localparam int XW     = $clog2(SCREEN_WIDTH);
	localparam int YW     = $clog2(SCREEN_HEIGHT);
	localparam int MAXD   = SCREEN_WIDTH > SCREEN_HEIGHT ? SCREEN_WIDTH : SCREEN_HEIGHT;
	localparam int NUM_W  = DEN_W + $clog2(MAXD) + 1;
	localparam int DV_W   = NUM_W > DQ_SHIFT + 1 ? NUM_W : DQ_SHIFT + 1;
	localparam logic [4:0] STEP_LAST = 5'd23;
	localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(PIXELS - 1);
	localparam logic signed [NUM_W-1:0] HALF_W  = NUM_W'(SCREEN_WIDTH / 2);
	localparam logic signed [NUM_W-1:0] QUART_W = NUM_W'(SCREEN_WIDTH / 4);
	localparam logic signed [NUM_W-1:0] HALF_H  = NUM_W'(SCREEN_HEIGHT / 2);
	localparam logic signed [NUM_W-1:0] QUART_H = NUM_W'(SCREEN_HEIGHT / 4);
	localparam logic [DV_W-1:0] DQ_NUM = DV_W'(1) << DQ_SHIFT;
	localparam logic [DV_W-1:0] W_LIM  = DV_W'(SCREEN_WIDTH);
	localparam logic [DV_W-1:0] H_LIM  = DV_W'(SCREEN_HEIGHT);

	typedef enum logic [11:0] {
		ST_INIT  = 12'b0000_0000_0001,
		ST_IDLE  = 12'b0000_0000_0010,
		ST_CLEAR = 12'b0000_0000_0100,
		ST_RD    = 12'b0000_0000_1000,
		ST_CALC  = 12'b0000_0001_0000,
		ST_DIVX  = 12'b0000_0010_0000,
		ST_DIVY  = 12'b0000_0100_0000,
		ST_DIVD  = 12'b0000_1000_0000,
		ST_ADDR  = 12'b0001_0000_0000,
		ST_MRD   = 12'b0010_0000_0000,
		ST_RMW   = 12'b0100_0000_0000,
		ST_OUT   = 12'b1000_0000_0000
	} state_t;

	state_t            state_q;
	logic [4:0]        step_q;
	logic [ADDR_W-1:0] clr_q;
	logic              ovalid_q;
	cfg_t              cfg_q;

	cmd_t                     cur_q;
	res_t                     res_q;
	res_t                     ores_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [33:0]       a_q, cph_q;
	logic signed [31:0]       spct_q, cpct_q, stsa_q, stca_q;
	logic signed [DEN_W-1:0]  den_q, t_q, m_q, px_q, py_q;
	logic signed [ACC_W-1:0]  acc_q, lum_q;
	logic signed [NUM_W-1:0]  nx_q, ny_q;
	logic [SHADE_W-1:0]       shade_q;
	logic [DEPTH_W-1:0]       dq_q;
	logic                     x_ok_q, y_ok_q;
	logic [XW-1:0]            x_q;
	logic [YW-1:0]            y_q;
	logic [ADDR_W-1:0]        o_q;

	logic [MEM_W-1:0]  mem [PIXELS];
	logic [MEM_W-1:0]  mem_rd_q;
	logic [ADDR_W-1:0] rd_addr_c;
	logic              wr_en_c;
	logic [ADDR_W-1:0] wr_addr_c;
	logic [MEM_W-1:0]  wr_data_c;

	logic signed [MUL_A_W-1:0] mul_a_c;
	logic signed [MUL_B_W-1:0] mul_b_c;
	logic                      out_free_c;
	logic                      den_pos_c;
	logic [NUM_W-1:0]          nx_mag_c, ny_mag_c;
	logic                      div_start_c;
	logic [DV_W-1:0]           div_dvd_c;
	logic                      div_done;
	logic [DV_W-1:0]           div_quo;
	logic [SHADE_W-1:0]        shade_c;
	logic [ACC_W-LUM_SHIFT-2:0] lum_hi_c;
	logic                      pass_c;

	assign out_free_c = !ovalid_q || out_ready;
	assign den_pos_c  = !den_q[DEN_W-1] && (den_q != '0);
	assign nx_mag_c   = nx_q[NUM_W-1] ? NUM_W'(-nx_q) : NUM_W'(nx_q);
	assign ny_mag_c   = ny_q[NUM_W-1] ? NUM_W'(-ny_q) : NUM_W'(ny_q);
	assign cmd_pop    = (state_q == ST_IDLE) && cmd_valid;
	assign stat.init_busy = state_q == ST_INIT;
	assign out_valid  = ovalid_q;
	assign out_res    = ores_q;
	assign pass_c     = dq_q > mem_rd_q[MEM_W-1:SHADE_W];

	// shade index from luminance, truncated and clamped
	always_comb begin
		lum_hi_c = lum_q[ACC_W-2:LUM_SHIFT];
		if (lum_q[ACC_W-1] || lum_q == '0)
			shade_c = '0;
		else if (lum_hi_c > (ACC_W - LUM_SHIFT - 1)'(SHADE_MAX))
			shade_c = SHADE_W'(SHADE_MAX);
		else
			shade_c = SHADE_W'(lum_hi_c);
	end

	// multiplier operand select per sequencer step
	always_comb begin
		mul_a_c = 34'(cur_q.sp);
		mul_b_c = cur_q.h;
		case (step_q)
			5'd0:  begin mul_a_c = 34'(cur_q.sp); mul_b_c = cur_q.h; end
			5'd1:  begin mul_a_c = 34'(cur_q.cp); mul_b_c = cur_q.h; end
			5'd2:  begin mul_a_c = 34'(cur_q.sp); mul_b_c = 18'(cur_q.ct); end
			5'd3:  begin mul_a_c = 34'(cur_q.st); mul_b_c = 18'(cfg_q.sin_a); end
			5'd4:  begin mul_a_c = 34'(cur_q.st); mul_b_c = 18'(cfg_q.cos_a); end
			5'd5:  begin mul_a_c = 34'(cur_q.cp); mul_b_c = 18'(cur_q.ct); end
			5'd6:  begin mul_a_c = a_q; mul_b_c = 18'(cfg_q.sin_a); end
			5'd7:  begin mul_a_c = a_q; mul_b_c = 18'(cfg_q.cos_a); end
			5'd8:  begin mul_a_c = 34'(spct_q); mul_b_c = 18'(cfg_q.cos_a); end
			5'd9:  begin mul_a_c = cph_q; mul_b_c = 18'(cfg_q.cos_b); end
			5'd10: begin
				mul_a_c = $signed({10'd0, t_q[SPLIT-1:0]});
				mul_b_c = 18'(cfg_q.sin_b);
			end
			5'd11: begin
				mul_a_c = 34'($signed(t_q[DEN_W-1:SPLIT]));
				mul_b_c = 18'(cfg_q.sin_b);
			end
			5'd12: begin mul_a_c = cph_q; mul_b_c = 18'(cfg_q.sin_b); end
			5'd13: begin
				mul_a_c = $signed({10'd0, t_q[SPLIT-1:0]});
				mul_b_c = 18'(cfg_q.cos_b);
			end
			5'd14: begin
				mul_a_c = 34'($signed(t_q[DEN_W-1:SPLIT]));
				mul_b_c = 18'(cfg_q.cos_b);
			end
			5'd15: begin
				mul_a_c = $signed({10'd0, m_q[SPLIT-1:0]});
				mul_b_c = 18'(cfg_q.cos_b);
			end
			5'd16: begin
				mul_a_c = 34'($signed(m_q[DEN_W-1:SPLIT]));
				mul_b_c = 18'(cfg_q.cos_b);
			end
			5'd17: begin mul_a_c = 34'(spct_q); mul_b_c = 18'(cfg_q.sin_a); end
			5'd18: begin mul_a_c = 34'(cpct_q); mul_b_c = 18'(cfg_q.sin_b); end
			default: begin mul_a_c = 34'(cur_q.sp); mul_b_c = cur_q.h; end
		endcase
	end

	// divider start and dividend select
	always_comb begin
		div_start_c = 1'b0;
		div_dvd_c   = DV_W'(nx_mag_c);
		case (state_q)
			ST_CALC: div_start_c = (step_q == STEP_LAST) && den_pos_c;
			ST_DIVX: begin div_start_c = div_done; div_dvd_c = DV_W'(ny_mag_c); end
			ST_DIVY: begin div_start_c = div_done; div_dvd_c = DQ_NUM; end
			default: div_start_c = 1'b0;
		endcase
	end

	tpz_div #(
		.DVD_W(DV_W),
		.DVS_W(DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_c),
		.dividend (div_dvd_c),
		.divisor  (DEN_W'(den_q)),
		.done     (div_done),
		.quotient (div_quo)
	);

	// store port select
	always_comb begin
		rd_addr_c = (state_q == ST_IDLE) ? ADDR_W'(cmd.idx) : o_q;
		wr_en_c   = 1'b0;
		wr_addr_c = clr_q;
		wr_data_c = {{DEPTH_W{1'b0}}, BLANK};
		case (state_q)
			ST_INIT, ST_CLEAR: wr_en_c = 1'b1;
			ST_RMW: begin
				wr_en_c   = pass_c;
				wr_addr_c = o_q;
				wr_data_c = {dq_q, shade_q};
			end
			default: wr_en_c = 1'b0;
		endcase
	end

	// depth and shade store
	always_ff @(posedge clk) begin
		if (wr_en_c) mem[wr_addr_c] <= wr_data_c;
		mem_rd_q <= mem[rd_addr_c];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			step_q   <= '0;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
			cfg_q    <= '{cos_a: COS_RST, sin_a: SIN_RST, cos_b: COS_RST, sin_b: SIN_RST};
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_COS_A: cfg_q.cos_a <= $signed(cfg_data);
					CFG_SIN_A: cfg_q.sin_a <= $signed(cfg_data);
					CFG_COS_B: cfg_q.cos_b <= $signed(cfg_data);
					CFG_SIN_B: cfg_q.sin_b <= $signed(cfg_data);
					default: ;
				endcase
			end
			if (state_q == ST_OUT && out_free_c) ovalid_q <= 1'b1;
			else if (out_ready)                  ovalid_q <= 1'b0;
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					if (clr_q == ADDR_LAST) begin
						clr_q   <= '0;
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_OUT;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.kind)
							KIND_CLEAR: state_q <= ST_CLEAR;
							KIND_PLOT: begin
								step_q  <= '0;
								state_q <= ST_CALC;
							end
							KIND_READ: state_q <= cmd.idx_ok ? ST_RD : ST_OUT;
							default:   state_q <= ST_OUT;
						endcase
					end
				end
				ST_RD: state_q <= ST_OUT;
				ST_CALC: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) state_q <= den_pos_c ? ST_DIVX : ST_OUT;
				end
				ST_DIVX: if (div_done) state_q <= ST_DIVY;
				ST_DIVY: if (div_done) state_q <= ST_DIVD;
				ST_DIVD: if (div_done) state_q <= (x_ok_q && y_ok_q) ? ST_ADDR : ST_OUT;
				ST_ADDR: state_q <= ST_MRD;
				ST_MRD:  state_q <= ST_RMW;
				ST_RMW:  state_q <= ST_OUT;
				ST_OUT:  if (out_free_c) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// shared multiplier, registered
	always_ff @(posedge clk) begin
		prod_q <= mul_a_c * mul_b_c;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free_c) ores_q <= res_q;
		case (state_q)
			ST_IDLE: begin
				cur_q <= cmd;
				res_q <= '{shade: BLANK, updated: 1'b0,
					index: (cmd.kind == KIND_READ) ? cmd.idx : '0};
			end
			ST_CLEAR: res_q <= '{shade: BLANK, updated: 1'b0, index: '0};
			ST_RD:    res_q.shade <= mem_rd_q[SHADE_W-1:0];
			ST_CALC: begin
				case (step_q)
					5'd1:  a_q    <= 34'(prod_q);
					5'd2:  cph_q  <= 34'(prod_q);
					5'd3:  spct_q <= 32'(prod_q);
					5'd4:  stsa_q <= 32'(prod_q);
					5'd5:  stca_q <= 32'(prod_q);
					5'd6:  cpct_q <= 32'(prod_q);
					5'd7:  den_q  <= DEN_W'(prod_q) + (DEN_W'(stca_q) <<< Q_FRAC) + FIVE_Q42;
					5'd8:  t_q    <= DEN_W'(prod_q) - (DEN_W'(stsa_q) <<< Q_FRAC);
					5'd9:  m_q    <= (DEN_W'(stsa_q) <<< Q_FRAC) - DEN_W'(prod_q);
					5'd10: px_q   <= DEN_W'(prod_q);
					5'd11: acc_q  <= ACC_W'(prod_q);
					5'd12: acc_q  <= acc_q + (ACC_W'(prod_q) <<< SPLIT);
					5'd13: begin
						py_q <= DEN_W'(prod_q);
						px_q <= px_q - DEN_W'(acc_q >>> Q_FRAC);
					end
					5'd14: acc_q  <= ACC_W'(prod_q);
					5'd15: acc_q  <= acc_q + (ACC_W'(prod_q) <<< SPLIT);
					5'd16: begin
						lum_q <= ACC_W'(prod_q);
						py_q  <= py_q + DEN_W'(acc_q >>> Q_FRAC);
					end
					5'd17: lum_q <= lum_q + (ACC_W'(prod_q) <<< SPLIT);
					5'd18: lum_q <= lum_q - (ACC_W'(prod_q) <<< Q_FRAC);
					5'd19: begin
						lum_q <= lum_q - (ACC_W'(prod_q) <<< Q_FRAC);
						nx_q  <= NUM_W'(den_q) * HALF_W;
					end
					5'd20: begin
						lum_q <= lum_q - (ACC_W'(stca_q) <<< (2 * Q_FRAC));
						nx_q  <= nx_q + NUM_W'(px_q) * QUART_W;
					end
					5'd21: ny_q <= NUM_W'(den_q) * HALF_H;
					5'd22: ny_q <= ny_q + NUM_W'(py_q) * QUART_H;
					5'd23: begin
						shade_q <= shade_c;
						res_q   <= '{shade: BLANK, updated: 1'b0, index: '0};
					end
					default: ;
				endcase
			end
			ST_DIVX: begin
				if (div_done) begin
					x_ok_q <= !((nx_q[NUM_W-1] && div_quo != '0) || div_quo >= W_LIM);
					x_q    <= XW'(div_quo);
				end
			end
			ST_DIVY: begin
				if (div_done) begin
					y_ok_q <= !((ny_q[NUM_W-1] && div_quo != '0) || div_quo >= H_LIM);
					y_q    <= YW'(div_quo);
				end
			end
			ST_DIVD: begin
				if (div_done) begin
					dq_q <= (div_quo[DV_W-1:DEPTH_W] != '0) ? {DEPTH_W{1'b1}}
						: div_quo[DEPTH_W-1:0];
				end
			end
			ST_ADDR: o_q <= ADDR_W'(x_q) + ADDR_W'(SCREEN_WIDTH) * ADDR_W'(y_q);
			ST_RMW:  res_q <= '{shade: shade_q, updated: pass_c, index: IDX_W'(o_q)};
			default: ;
		endcase
	end

endmodule

// ----- hdl/torus_point_zbuffer_plot.sv -----
// top level of the torus point depth-buffer plotter
`timescale 1ns / 1ps
// Each item is one command. A plot item rotates a torus surface point by the
// configured angles, projects it, shades it and writes it into the character
// store where its depth beats the stored one; it passes through the product
// sequencer, which shares one 34x18 multiplier, then three runs of the
// bit-serial divider (x, y and reciprocal depth), plus dispatch, store access
// and output. A read goes through the store's registered read port. A clear
// sweeps the store one entry a cycle. After reset the same sweep runs with
// s_axis_tready low. A two-entry command queue and the output register let new
// items be taken while a result waits on m_axis_tready.
module torus_point_zbuffer_plot
	import tpz_pkg::*;
#(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// ring_cos, ring_sin, tube_cos, tube_sin, pixel_index, zero pad
	input  logic [79:0] s_axis_tdata,
	// action
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// shade_code, screen_index, zero pad
	output logic [23:0] m_axis_tdata,
	// updated
	output logic        m_axis_tuser,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cmd_t  push_cmd;
	cmd_t  pop_cmd;
	logic  push;
	logic  full;
	logic  pop;
	logic  cmd_valid;
	stat_t stat;
	res_t  res;

	tpz_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.full          (full),
		.stat          (stat),
		.push          (push),
		.cmd           (push_cmd)
	);

	tpz_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.full   (full),
		.pop    (pop),
		.dout   (pop_cmd),
		.valid  (cmd_valid)
	);

	tpz_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (pop_cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	// result packing
	assign m_axis_tdata = {5'd0, res.index, res.shade};
	assign m_axis_tuser = res.updated;

endmodule

// ----- verif/tb.sv -----
// self-checking testbench of the torus point depth-buffer plotter
`timescale 1ns / 1ps
module tb;
	import tpz_pkg::*;

	localparam int W      = 200;
	localparam int H      = 160;
	localparam int PIXELS = W * H;
	localparam int DRAIN  = 300;
	localparam real PI    = 3.14159265358979;

	typedef struct {
		logic [1:0]         act;
		logic signed [15:0] rc;
		logic signed [15:0] rs;
		logic signed [15:0] tc;
		logic signed [15:0] ts;
		logic [14:0]        pix;
		bit                 typed;
		res_t               want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// predictor state
	logic signed [15:0] p_cos_a = COS_RST, p_sin_a = SIN_RST;
	logic signed [15:0] p_cos_b = COS_RST, p_sin_b = SIN_RST;
	logic [15:0] depth_mem [PIXELS];
	logic [3:0]  shade_mem [PIXELS];
	res_t        pending_shades [$];
	row_t        rows [$];
	int          errors = 0;
	bit          calm = 0;
	bit          hold_req = 0;
	logic [14:0] last_hit = '0;

	torus_point_zbuffer_plot dut (.*);

	always #5 clk = ~clk;

	// clear both stores of the predictor
	task automatic wipe_stores();
		for (int i = 0; i < PIXELS; i++) begin
			depth_mem[i] = '0;
			shade_mem[i] = BLANK;
		end
	endtask

	// expected result of one item, stores updated
	task automatic predict_plot(input logic [1:0] act, input logic signed [15:0] rc,
			input logic signed [15:0] rs, input logic signed [15:0] tc,
			input logic signed [15:0] ts, input logic [14:0] pix, output res_t r);
		longint cA, sA, cB, sB, ct, st, cp, sp, h, a, cph, spct, cpct;
		longint den, t, px, py, x, y, dq, lum, shade, o;
		r = '{BLANK, 1'b0, 15'd0};
		if (act == ACT_CLEAR) begin
			wipe_stores();
		end else if (act == ACT_READ) begin
			r.index = pix;
			if (pix < PIXELS) r.shade = shade_mem[pix];
		end else if (act == ACT_PLOT) begin
			cA = p_cos_a; sA = p_sin_a; cB = p_cos_b; sB = p_sin_b;
			ct = rc; st = rs; cp = tc; sp = ts;
			h = ct + 32768;
			a = sp * h;
			cph = cp * h;
			spct = sp * ct;
			cpct = cp * ct;
			den = a * sA + st * cA * 16384 + (longint'(5) << 42);
			if (den > 0) begin
				t = a * cA - st * sA * 16384;
				px = cph * cB - ((t * sB) >>> 14);
				py = cph * sB + ((t * cB) >>> 14);
				x = (longint'(W / 2) * den + longint'(W / 4) * px) / den;
				y = (longint'(H / 2) * den + longint'(H / 4) * py) / den;
				if (x >= 0 && x < W && y >= 0 && y < H) begin
					dq = (longint'(1) << 57) / den;
					if (dq > 65535) dq = 65535;
					lum = (st * sA * 16384 - spct * cA) * cB - spct * sA * 16384
						- st * cA * 16384 * 16384 - cpct * sB * 16384;
					shade = lum <= 0 ? 0 : (lum >>> 53);
					if (shade > 11) shade = 11;
					o = x + W * y;
					r.shade = shade[3:0];
					r.index = o[14:0];
					last_hit = o[14:0];
					if (dq > longint'(depth_mem[o])) begin
						depth_mem[o] = dq[15:0];
						shade_mem[o] = shade[3:0];
						r.updated = 1'b1;
					end
				end
			end
		end
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offer one item, wait for acceptance, queue its expected result
	task automatic send_item(input logic [1:0] act, input logic signed [15:0] rc,
			input logic signed [15:0] rs, input logic signed [15:0] tc,
			input logic signed [15:0] ts, input logic [14:0] pix,
			input bit typed, input res_t want);
		bit ok;
		res_t r;
		int g;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {1'b0, pix, ts, tc, rs, rc};
		do begin
			@(negedge clk);
			ok = s_axis_tready;
			@(posedge clk);
		end while (!ok);
		predict_plot(act, rc, rs, tc, ts, pix, r);
		pending_shades.push_back(typed ? want : r);
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (pending_shades.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// write all four angle registers while idle
	task automatic set_angles(input logic signed [15:0] ca, input logic signed [15:0] sa,
			input logic signed [15:0] cb, input logic signed [15:0] sb);
		logic [15:0] v [4];
		v[0] = ca; v[1] = sa; v[2] = cb; v[3] = sb;
		s_axis_tvalid <= 1'b0;
		wait_drained();
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= i[1:0];
			cfg_data  <= v[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		p_cos_a = ca; p_sin_a = sa; p_cos_b = cb; p_sin_b = sb;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] q14(input real v);
		return 16'($rtoi(v * 16384.0));
	endfunction

	function automatic logic signed [15:0] rnd16(input bit wide);
		if (wide) return 16'($urandom);
		return 16'($urandom_range(0, 32768) - 16384);
	endfunction

	task automatic add_row(input logic [1:0] act, input logic signed [15:0] rc,
			input logic signed [15:0] rs, input logic signed [15:0] tc,
			input logic signed [15:0] ts, input logic [14:0] pix,
			input bit typed, input res_t want);
		row_t e;
		e.act = act; e.rc = rc; e.rs = rs; e.tc = tc; e.ts = ts;
		e.pix = pix; e.typed = typed; e.want = want;
		rows.push_back(e);
	endtask

	// one random item, mostly points on the torus
	task automatic random_item();
		int r;
		real th, ph;
		logic [1:0] act;
		logic signed [15:0] rc, rs, tc, ts;
		logic [14:0] pix;
		r = $urandom_range(0, 999);
		pix = 15'($urandom);
		th = 2.0 * PI * $urandom_range(0, 9999) / 10000.0;
		ph = 2.0 * PI * $urandom_range(0, 9999) / 10000.0;
		rc = q14($cos(th)); rs = q14($sin(th));
		tc = q14($cos(ph)); ts = q14($sin(ph));
		act = ACT_PLOT;
		if (r < 4) begin
			act = ACT_CLEAR;
		end else if (r < 20) begin
			act = 2'(KIND_NONE);
		end else if (r < 60) begin
			act = ACT_READ;
		end else if (r < 100) begin
			act = ACT_READ;
			pix = last_hit;
		end else if (r < 180) begin
			rc = rnd16(0); rs = rnd16(0); tc = rnd16(0); ts = rnd16(0);
		end else if (r < 230) begin
			rc = rnd16(1); rs = rnd16(1); tc = rnd16(1); ts = rnd16(1);
		end
		send_item(act, rc, rs, tc, ts, pix, 0, '0);
	endtask

	// receiver readiness with random stalls and one long hold
	initial begin
		int stall;
		int hold;
		stall = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold = 3000;
				hold_req = 0;
			end
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				stall = gap_len();
			end
		end
	end

	// result checking against the oldest expectation
	always @(negedge clk) begin
		res_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_shades.size() == 0) begin
				$error("unexpected item: shade_code %0d updated %0d screen_index %0d",
					m_axis_tdata[3:0], m_axis_tuser, m_axis_tdata[18:4]);
				errors++;
			end else begin
				exp_r = pending_shades.pop_front();
				if (m_axis_tdata[3:0] !== exp_r.shade) begin
					$error("shade_code expected %0d actual %0d", exp_r.shade,
						m_axis_tdata[3:0]);
					errors++;
				end
				if (m_axis_tuser !== exp_r.updated) begin
					$error("updated expected %0d actual %0d", exp_r.updated, m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata[18:4] !== exp_r.index) begin
					$error("screen_index expected %0d actual %0d", exp_r.index,
						m_axis_tdata[18:4]);
					errors++;
				end
			end
		end
	end

	// run limit
	initial begin
		#80ms;
		$display("Verification failed");
		$finish;
	end

	// stimulus
	initial begin
		logic signed [15:0] set_tab [6][4];
		real ang;
		wipe_stores();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset angles
		add_row(ACT_READ, 0, 0, 0, 0, 15'd0, 1, '{BLANK, 1'b0, 15'd0});
		add_row(ACT_READ, 0, 0, 0, 0, 15'd31999, 1, '{BLANK, 1'b0, 15'd31999});
		add_row(ACT_READ, 0, 0, 0, 0, 15'd32767, 1, '{BLANK, 1'b0, 15'd32767});
		add_row(2'(KIND_NONE), 0, 0, 0, 0, 15'd0, 1, '{BLANK, 1'b0, 15'd0});
		add_row(ACT_PLOT, 16384, 0, 16384, 0, 15'd0, 0, '0);
		add_row(ACT_PLOT, 16384, 0, 16384, 0, 15'd0, 0, '0);
		add_row(ACT_PLOT, -16384, 0, -16384, 0, 15'd0, 0, '0);
		add_row(ACT_PLOT, 0, 16384, 0, 16384, 15'd0, 0, '0);
		add_row(ACT_PLOT, 0, -16384, 0, -16384, 15'd0, 0, '0);
		add_row(ACT_PLOT, 16384, 16384, 16384, 16384, 15'd0, 0, '0);
		add_row(ACT_PLOT, -16384, -16384, -16384, -16384, 15'd0, 0, '0);
		add_row(ACT_PLOT, -32768, 32767, -32768, 32767, 15'h7fff, 0, '0);
		add_row(ACT_READ, 0, 0, 0, 0, 15'd16100, 0, '0);
		add_row(ACT_CLEAR, 0, 0, 0, 0, 15'd0, 1, '{BLANK, 1'b0, 15'd0});
		add_row(ACT_READ, 0, 0, 0, 0, 15'd16100, 1, '{BLANK, 1'b0, 15'd16100});
		add_row(ACT_PLOT, 16384, 0, 16384, 0, 15'd0, 0, '0);
		foreach (rows[i])
			send_item(rows[i].act, rows[i].rc, rows[i].rs, rows[i].tc, rows[i].ts,
				rows[i].pix, rows[i].typed, rows[i].want);

		// angle settings per phase, extremes first
		set_tab[0] = '{16384, 0, 16384, 0};
		set_tab[1] = '{-16384, 0, -16384, 0};
		set_tab[2] = '{0, 16384, 0, -16384};
		ang = 2.0 * PI * $urandom_range(0, 999) / 1000.0;
		set_tab[3] = '{q14($cos(ang)), q14($sin(ang)), q14($sin(ang)), q14($cos(ang))};
		set_tab[4] = '{COS_RST, SIN_RST, COS_RST, SIN_RST};
		set_tab[5] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};

		for (int ph = 0; ph < 6; ph++) begin
			set_angles(set_tab[ph][0], set_tab[ph][1], set_tab[ph][2], set_tab[ph][3]);
			calm = (ph == 4);
			for (int n = 0; n < 222; n++) begin
				if (ph == 1 && n == 10) hold_req = 1;
				if (ph == 3 && n == 100) begin
					// sender pause until every result is back
					s_axis_tvalid <= 1'b0;
					while (pending_shades.size() != 0) @(posedge clk);
				end
				random_item();
			end
		end
		calm = 0;
		s_axis_tvalid <= 1'b0;
		wait_drained();
		if (errors == 0 && pending_shades.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
